[rtl/pll_synth_register_calculator_unit_macros.svh]
// Assertion macros shared by the checker of the synthesizer word calculator.
// Clocked on the given clock, disabled while the given active-low reset is low.
`ifndef PLL_SYNTH_REGISTER_CALCULATOR_UNIT_MACROS_SVH
`define PLL_SYNTH_REGISTER_CALCULATOR_UNIT_MACROS_SVH

// Same-cycle implication
`define PSCU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pscu check failed");

// Next-cycle implication
`define PSCU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pscu check failed");

`endif

[rtl/pscu_pkg.sv]
// Package for the synthesizer word calculator: widths, limits, fixed word fields,
// state and select codes, and the structs passed between modules. No dependencies.
`timescale 1ns / 1ps

package pscu_pkg;

    // Field widths
    localparam int FREQ_W   = 33;
    localparam int CHAN_W   = 27;
    localparam int REF_W    = 28;
    localparam int P_W      = 29;
    localparam int RDIV_W   = 10;
    localparam int D_W      = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 28;

    // Shared divider and multiplier widths
    localparam int DIVD_W   = 44;
    localparam int DVS_W    = 30;
    localparam int MUL_A_W  = 33;
    localparam int MUL_B_W  = 12;
    localparam int PROD_W   = MUL_A_W + MUL_B_W;

    // Frequency limits in hertz
    localparam logic [FREQ_W-1:0] LOW_HZ     = 33'd34375000;
    localparam logic [FREQ_W-1:0] HIGH_HZ    = 33'd4400000000;
    localparam logic [FREQ_W-1:0] VCO_LOW_HZ = 33'd2200000000;

    // Divider and modulus limits
    localparam logic [11:0] MOD_MAX     = 12'd4095;
    localparam logic [11:0] MOD_MIN     = 12'd2;
    localparam logic [15:0] PRESC_LIMIT = 16'd75;
    localparam logic [15:0] INT_MIN_VAL = 16'd23;
    localparam logic [15:0] INT_SAT     = 16'hFFFF;

    // Reset values of the configuration registers
    localparam logic [REF_W-1:0]  REF_FREQ_RST = 28'd10000000;
    localparam logic [RDIV_W-1:0] R_DIV_RST    = 10'd1;

    // Fixed fields of the control words
    localparam logic [13:0] W2_LOW  = 14'h0DC2;
    localparam logic [19:0] W4_LOW  = 20'h0003C;
    localparam logic [31:0] W3_WORD = 32'h0060_0003;
    localparam logic [31:0] W5_WORD = 32'h0040_0005;
    localparam logic [2:0]  W1_CTRL = 3'd1;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_FREQ = 2'd0,
        CFG_DOUBLER  = 2'd1,
        CFG_HALVE    = 2'd2,
        CFG_R_DIV    = 2'd3
    } t_cfg_idx;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL_VD,
        ST_DIV_INT_GO,
        ST_DIV_INT,
        ST_MODE,
        ST_MUL_DD,
        ST_MOD_GO,
        ST_DIV_MOD,
        ST_MUL_RM,
        ST_FRAC_GO,
        ST_DIV_FRAC,
        ST_CARRY,
        ST_PACK,
        ST_OUT
    } t_state;

    // Multiplier operand select
    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_VD,
        MUL_DD,
        MUL_RM
    } t_mul_sel;

    // Configuration register contents
    typedef struct packed {
        logic [REF_W-1:0]  ref_freq_hz;
        logic              ref_doubler;
        logic              ref_halve;
        logic [RDIV_W-1:0] r_divider;
    } t_cfg;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

[rtl/pscu_cfg.sv]
// Configuration register file of the synthesizer word calculator.
// Depends on pscu_pkg for widths, index codes and the register struct.
`timescale 1ns / 1ps

module pscu_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pscu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pscu_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output pscu_pkg::t_cfg                      o_cfg
);

    pscu_pkg::t_cfg r_cfg;
    pscu_pkg::t_cfg n_cfg;

    // Decode the write
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (pscu_pkg::t_cfg_idx'(i_cfg_idx))
                pscu_pkg::CFG_REF_FREQ: n_cfg.ref_freq_hz = i_cfg_wdata[pscu_pkg::REF_W-1:0];
                pscu_pkg::CFG_DOUBLER:  n_cfg.ref_doubler = i_cfg_wdata[0];
                pscu_pkg::CFG_HALVE:    n_cfg.ref_halve   = i_cfg_wdata[0];
                pscu_pkg::CFG_R_DIV:    n_cfg.r_divider   = i_cfg_wdata[pscu_pkg::RDIV_W-1:0];
                default: ;
            endcase
        end
    end

    // Hold the registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_freq_hz <= pscu_pkg::REF_FREQ_RST;
            r_cfg.ref_doubler <= 1'b0;
            r_cfg.ref_halve   <= 1'b0;
            r_cfg.r_divider   <= pscu_pkg::R_DIV_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/pscu_div.sv]
// Shared restoring divider: one quotient bit per cycle over the full dividend width.
// Depends on pscu_pkg for the operand widths and the status struct.
`timescale 1ns / 1ps

module pscu_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pscu_pkg::DIVD_W-1:0]      i_dividend,
    input  logic [pscu_pkg::DVS_W-1:0]       i_divisor,
    output pscu_pkg::t_div_stat              o_stat,
    output logic [pscu_pkg::DIVD_W-1:0]      o_quotient,
    output logic [pscu_pkg::DVS_W-1:0]       o_remainder
);

    localparam int CNT_W = $clog2(pscu_pkg::DIVD_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(pscu_pkg::DIVD_W - 1);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [pscu_pkg::DIVD_W-1:0]   r_quo;
    logic [pscu_pkg::DVS_W-1:0]    r_rem;
    logic [pscu_pkg::DVS_W-1:0]    r_dvs;

    logic [pscu_pkg::DVS_W:0]      s_shifted;
    logic [pscu_pkg::DVS_W:0]      s_diff;
    logic                          s_ge;
    logic [pscu_pkg::DVS_W-1:0]    n_rem;
    logic [pscu_pkg::DIVD_W-1:0]   n_quo;

    // One restoring step: shift in the next dividend bit, trial subtract
    always_comb begin
        s_shifted = {r_rem, r_quo[pscu_pkg::DIVD_W-1]};
        s_diff    = s_shifted - {1'b0, r_dvs};
        s_ge      = (s_shifted >= {1'b0, r_dvs});
        n_rem     = s_ge ? s_diff[pscu_pkg::DVS_W-1:0] : s_shifted[pscu_pkg::DVS_W-1:0];
        n_quo     = {r_quo[pscu_pkg::DIVD_W-2:0], s_ge};
    end

    // Advance the step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Load operands, then iterate
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

[rtl/pll_synth_register_calculator_unit.sv]
// Top level of the fractional-N synthesizer control word calculator.
// Depends on pscu_pkg, pscu_cfg (register file) and pscu_div (shared divider).
`timescale 1ns / 1ps

// Turns a requested output frequency and channel spacing into six 32-bit synthesizer
// control words, one result item per input item. The block takes one item at a time.
// In fractional mode three divisions (INT, MOD, FRAC) of 44 steps each run on the one
// shared restoring divider; MOD is skipped when the reference is below twice the
// spacing times the reference divider. In integer mode (spacing below 2) only the INT
// division runs. An out-of-range frequency goes straight to the result, and a zero
// reference skips the divisions. The next item is accepted in the cycle after the
// result is loaded. The result sits in an output register, so the next item may
// enter while it waits to be taken; a result that cannot be loaded holds the sequencer.
// A failed range check returns status 1 with the previous words, all zero after reset.

module pll_synth_register_calculator_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [pscu_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [pscu_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [pscu_pkg::FREQ_W-1:0]         i_out_freq_hz,
    input  logic [pscu_pkg::CHAN_W-1:0]         i_chan_spacing_hz,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_status,
    output logic [31:0]                         o_word0,
    output logic [31:0]                         o_word1,
    output logic [31:0]                         o_word2,
    output logic [31:0]                         o_word3,
    output logic [31:0]                         o_word4,
    output logic [31:0]                         o_word5
);

    pscu_pkg::t_cfg        s_cfg;
    pscu_pkg::t_div_stat   s_div_stat;
    logic [pscu_pkg::DIVD_W-1:0] s_quo;
    logic [pscu_pkg::DVS_W-1:0]  s_dvd_rem;

    // Sequencer and datapath registers
    pscu_pkg::t_state                r_state, n_state;
    logic [pscu_pkg::FREQ_W-1:0]     r_f, n_f;
    logic [pscu_pkg::CHAN_W-1:0]     r_ch, n_ch;
    logic [2:0]                      r_sel, n_sel;
    logic [pscu_pkg::FREQ_W-1:0]     r_vco, n_vco;
    logic [pscu_pkg::P_W-1:0]        r_p, n_p;
    logic [pscu_pkg::D_W-1:0]        r_d, n_d;
    logic [pscu_pkg::PROD_W-1:0]     r_prod, n_prod;
    logic [pscu_pkg::DIVD_W-1:0]     r_nint, n_nint;
    logic [pscu_pkg::P_W-1:0]        r_rem, n_rem;
    logic [11:0]                     r_mod, n_mod;
    logic [11:0]                     r_frac, n_frac;
    logic                            r_status, n_status;
    logic [31:0]                     r_last [0:5];
    logic [31:0]                     n_last [0:5];
    logic                            r_out_valid;
    logic                            r_out_status;
    logic [31:0]                     r_out_word [0:5];

    // Control outputs of the sequencer
    logic                            s_out_load;
    logic                            s_div_start;
    logic [pscu_pkg::DIVD_W-1:0]     s_div_dividend;
    logic [pscu_pkg::DVS_W-1:0]      s_div_divisor;
    pscu_pkg::t_mul_sel              s_mul_sel;
    logic [pscu_pkg::MUL_A_W-1:0]    s_mul_a;
    logic [pscu_pkg::MUL_B_W-1:0]    s_mul_b;

    // Decision signals
    logic [pscu_pkg::FREQ_W+5:0]     s_shift [0:6];
    logic [6:0]                      s_hit;
    logic                            s_found;
    logic [2:0]                      s_sel_k;
    logic                            s_range_ok;
    logic                            s_p_zero;
    logic [pscu_pkg::FREQ_W+5:0]     s_two_dd;
    logic                            s_mod_small;
    logic                            s_p89;
    logic [15:0]                     s_int16;
    logic [pscu_pkg::D_W-1:0]        s_d_base;

    pscu_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (s_cfg)
    );

    pscu_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (s_div_start),
        .i_dividend  (s_div_dividend),
        .i_divisor   (s_div_divisor),
        .o_stat      (s_div_stat),
        .o_quotient  (s_quo),
        .o_remainder (s_dvd_rem)
    );

    // Find the lowest power-of-two divider that lands the oscillator in band
    always_comb begin
        for (int k = 0; k < 7; k++) begin
            s_shift[k] = {6'd0, r_f} << k;
            s_hit[k]   = (s_shift[k] >= {6'd0, pscu_pkg::VCO_LOW_HZ})
                      && (s_shift[k] <= {6'd0, pscu_pkg::HIGH_HZ});
        end
        s_found = |s_hit;
        s_sel_k = '0;
        for (int k = 6; k >= 0; k--) begin
            if (s_hit[k]) begin
                s_sel_k = 3'(k);
            end
        end
    end

    // Range check, zero reference, modulus bound and prescaler decisions
    always_comb begin
        s_range_ok  = (r_f >= pscu_pkg::LOW_HZ) && (r_f <= pscu_pkg::HIGH_HZ) && s_found;
        s_p_zero    = (r_p == '0);
        s_two_dd    = {r_prod[37:0], 1'b0};
        s_mod_small = ({10'd0, r_p} < s_two_dd);
        s_p89       = (r_nint > 44'(pscu_pkg::PRESC_LIMIT));
        if (r_nint > 44'(pscu_pkg::INT_SAT)) begin
            s_int16 = pscu_pkg::INT_SAT;
        end else if (!s_p89 && (r_nint < 44'(pscu_pkg::INT_MIN_VAL))) begin
            s_int16 = pscu_pkg::INT_MIN_VAL;
        end else begin
            s_int16 = r_nint[15:0];
        end
        s_d_base = (s_cfg.r_divider == '0) ? 11'd1 : {1'b0, s_cfg.r_divider};
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            pscu_pkg::ST_IDLE:       if (i_in_valid) n_state = pscu_pkg::ST_CHECK;
            pscu_pkg::ST_CHECK:      n_state = s_range_ok ? pscu_pkg::ST_MUL_VD
                                                          : pscu_pkg::ST_OUT;
            pscu_pkg::ST_MUL_VD:     n_state = pscu_pkg::ST_DIV_INT_GO;
            pscu_pkg::ST_DIV_INT_GO: n_state = s_p_zero ? pscu_pkg::ST_MODE
                                                        : pscu_pkg::ST_DIV_INT;
            pscu_pkg::ST_DIV_INT:    if (s_div_stat.done) n_state = pscu_pkg::ST_MODE;
            pscu_pkg::ST_MODE:       n_state = (r_ch < 27'd2) ? pscu_pkg::ST_CARRY
                                                              : pscu_pkg::ST_MUL_DD;
            pscu_pkg::ST_MUL_DD:     n_state = pscu_pkg::ST_MOD_GO;
            pscu_pkg::ST_MOD_GO:     n_state = s_mod_small ? pscu_pkg::ST_MUL_RM
                                                           : pscu_pkg::ST_DIV_MOD;
            pscu_pkg::ST_DIV_MOD:    if (s_div_stat.done) n_state = pscu_pkg::ST_MUL_RM;
            pscu_pkg::ST_MUL_RM:     n_state = pscu_pkg::ST_FRAC_GO;
            pscu_pkg::ST_FRAC_GO:    n_state = s_p_zero ? pscu_pkg::ST_CARRY
                                                        : pscu_pkg::ST_DIV_FRAC;
            pscu_pkg::ST_DIV_FRAC:   if (s_div_stat.done) n_state = pscu_pkg::ST_CARRY;
            pscu_pkg::ST_CARRY:      n_state = pscu_pkg::ST_PACK;
            pscu_pkg::ST_PACK:       n_state = pscu_pkg::ST_OUT;
            pscu_pkg::ST_OUT:        if (!r_out_valid || !i_out_stall) n_state = pscu_pkg::ST_IDLE;
            default:                 n_state = pscu_pkg::ST_IDLE;
        endcase
    end

    // Sequencer outputs: result load, divider start and operands, multiplier select
    always_comb begin
        s_out_load     = 1'b0;
        s_div_start    = 1'b0;
        s_div_dividend = '0;
        s_div_divisor  = '0;
        s_mul_sel      = pscu_pkg::MUL_NONE;
        case (r_state)
            pscu_pkg::ST_MUL_VD: begin
                s_mul_sel = pscu_pkg::MUL_VD;
            end
            pscu_pkg::ST_DIV_INT_GO: begin
                s_div_start    = !s_p_zero;
                s_div_dividend = r_prod[pscu_pkg::DIVD_W-1:0];
                s_div_divisor  = 30'(r_p);
            end
            pscu_pkg::ST_MUL_DD: begin
                s_mul_sel = pscu_pkg::MUL_DD;
            end
            pscu_pkg::ST_MOD_GO: begin
                s_div_start    = !s_mod_small;
                s_div_dividend = 44'({r_p, 1'b0}) + 44'(r_prod[37:0]);
                s_div_divisor  = s_two_dd[pscu_pkg::DVS_W-1:0];
            end
            pscu_pkg::ST_MUL_RM: begin
                s_mul_sel = pscu_pkg::MUL_RM;
            end
            pscu_pkg::ST_FRAC_GO: begin
                s_div_start    = !s_p_zero;
                s_div_dividend = 44'({r_prod[40:0], 1'b0}) + 44'(r_p);
                s_div_divisor  = {r_p, 1'b0};
            end
            pscu_pkg::ST_OUT: begin
                s_out_load = !r_out_valid || !i_out_stall;
            end
            default: ;
        endcase
    end

    // Shared multiplier operand select
    always_comb begin
        case (s_mul_sel)
            pscu_pkg::MUL_VD: begin
                s_mul_a = r_vco;
                s_mul_b = 12'(r_d);
            end
            pscu_pkg::MUL_DD: begin
                s_mul_a = 33'(r_ch);
                s_mul_b = 12'(r_d);
            end
            pscu_pkg::MUL_RM: begin
                s_mul_a = 33'(r_rem);
                s_mul_b = r_mod;
            end
            default: begin
                s_mul_a = '0;
                s_mul_b = '0;
            end
        endcase
        n_prod = pscu_pkg::PROD_W'(s_mul_a) * pscu_pkg::PROD_W'(s_mul_b);
    end

    // Datapath next values
    always_comb begin
        n_f      = r_f;
        n_ch     = r_ch;
        n_sel    = r_sel;
        n_vco    = r_vco;
        n_p      = r_p;
        n_d      = r_d;
        n_nint   = r_nint;
        n_rem    = r_rem;
        n_mod    = r_mod;
        n_frac   = r_frac;
        n_status = r_status;
        for (int i = 0; i < 6; i++) begin
            n_last[i] = r_last[i];
        end
        case (r_state)
            pscu_pkg::ST_IDLE: begin
                n_f  = i_out_freq_hz;
                n_ch = i_chan_spacing_hz;
            end
            pscu_pkg::ST_CHECK: begin
                n_status = !s_range_ok;
                n_sel    = s_sel_k;
                n_vco    = s_shift[s_sel_k][pscu_pkg::FREQ_W-1:0];
                n_p      = s_cfg.ref_doubler ? {s_cfg.ref_freq_hz, 1'b0}
                                             : {1'b0, s_cfg.ref_freq_hz};
                n_d      = s_cfg.ref_halve ? {s_d_base[pscu_pkg::D_W-2:0], 1'b0} : s_d_base;
            end
            pscu_pkg::ST_DIV_INT_GO: begin
                if (s_p_zero) begin
                    n_nint = 44'(pscu_pkg::INT_SAT);
                    n_rem  = '0;
                end
            end
            pscu_pkg::ST_DIV_INT: begin
                if (s_div_stat.done) begin
                    n_nint = s_quo;
                    n_rem  = s_dvd_rem[pscu_pkg::P_W-1:0];
                end
            end
            pscu_pkg::ST_MODE: begin
                n_mod  = pscu_pkg::MOD_MIN;
                n_frac = '0;
            end
            pscu_pkg::ST_MOD_GO: begin
                n_mod = pscu_pkg::MOD_MIN;
            end
            pscu_pkg::ST_DIV_MOD: begin
                if (s_div_stat.done) begin
                    n_mod = (s_quo > 44'(pscu_pkg::MOD_MAX)) ? pscu_pkg::MOD_MAX : s_quo[11:0];
                end
            end
            pscu_pkg::ST_FRAC_GO: begin
                n_frac = '0;
            end
            pscu_pkg::ST_DIV_FRAC: begin
                if (s_div_stat.done) begin
                    n_frac = s_quo[11:0];
                end
            end
            pscu_pkg::ST_CARRY: begin
                // Fold a rounded-up fraction into INT
                if (r_frac >= r_mod) begin
                    n_frac = '0;
                    n_nint = r_nint + 1'b1;
                end
            end
            pscu_pkg::ST_PACK: begin
                n_last[0] = {1'b0, s_int16, r_frac, 3'd0};
                n_last[1] = {4'd0, s_p89, 11'd0, 1'b1, r_mod, pscu_pkg::W1_CTRL};
                n_last[2] = {6'd0, s_cfg.ref_doubler, s_cfg.ref_halve, s_cfg.r_divider,
                             pscu_pkg::W2_LOW};
                n_last[3] = pscu_pkg::W3_WORD;
                n_last[4] = {8'd0, 1'b1, r_sel, pscu_pkg::W4_LOW};
                n_last[5] = pscu_pkg::W5_WORD;
            end
            default: ;
        endcase
    end

    // Control state and word store
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pscu_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            for (int i = 0; i < 6; i++) begin
                r_last[i] <= n_last[i];
            end
            if (s_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath payload
    always_ff @(posedge i_clk) begin
        r_f      <= n_f;
        r_ch     <= n_ch;
        r_sel    <= n_sel;
        r_vco    <= n_vco;
        r_p      <= n_p;
        r_d      <= n_d;
        r_prod   <= n_prod;
        r_nint   <= n_nint;
        r_rem    <= n_rem;
        r_mod    <= n_mod;
        r_frac   <= n_frac;
        r_status <= n_status;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_out_status <= r_status;
            for (int i = 0; i < 6; i++) begin
                r_out_word[i] <= r_last[i];
            end
        end
    end

    assign o_in_stall  = (r_state != pscu_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_word0     = r_out_word[0];
    assign o_word1     = r_out_word[1];
    assign o_word2     = r_out_word[2];
    assign o_word3     = r_out_word[3];
    assign o_word4     = r_out_word[4];
    assign o_word5     = r_out_word[5];

endmodule

[rtl/pscu_chk.sv]
// Port-level checker for the synthesizer word calculator, bound to the top level.
// Depends on pscu_pkg for fixed word values and on the assertion macro header.
`timescale 1ns / 1ps
`include "pll_synth_register_calculator_unit_macros.svh"

module pscu_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic                                o_status,
    input  logic [31:0]                         o_word0,
    input  logic [31:0]                         o_word1,
    input  logic [31:0]                         o_word2,
    input  logic [31:0]                         o_word3,
    input  logic [31:0]                         o_word4,
    input  logic [31:0]                         o_word5
);

    logic [192:0] s_payload;
    logic         s_out_held;
    logic         s_in_accept;
    logic         s_good;
    logic         s_fixed_ok;
    logic         s_order_ok;

    // Gather the result item and the conditions checked on it
    assign s_payload   = {o_status, o_word0, o_word1, o_word2, o_word3, o_word4, o_word5};
    assign s_out_held  = o_out_valid && i_out_stall;
    assign s_in_accept = i_in_valid && !o_in_stall;
    assign s_good      = o_out_valid && !o_status;
    assign s_fixed_ok  = (o_word3 == pscu_pkg::W3_WORD) && (o_word5 == pscu_pkg::W5_WORD)
                      && o_word1[15] && (o_word1[2:0] == pscu_pkg::W1_CTRL);
    assign s_order_ok  = (o_word0[30:15] >= pscu_pkg::INT_MIN_VAL)
                      && (o_word1[14:3] >= pscu_pkg::MOD_MIN)
                      && (o_word0[14:3] < o_word1[14:3]);

    // A stalled result keeps its valid and payload
    `PSCU_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, s_out_held, o_out_valid && $stable(s_payload))

    // An accepted item keeps the input side closed while it is worked on
    `PSCU_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, s_in_accept, o_in_stall)

    // A good result carries the fixed words and control bits
    `PSCU_ASSERT_IMP(a_fixed_words, i_clk, i_rst_n, s_good, s_fixed_ok)

    // A good result has INT and MOD at their floors or above and FRAC below MOD
    `PSCU_ASSERT_IMP(a_int_frac_mod, i_clk, i_rst_n, s_good, s_order_ok)

endmodule

bind pll_synth_register_calculator_unit pscu_chk u_pscu_chk (.*);
